[sv/pesa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the priority evicting slot allocator.
// No dependencies; imported by pesa_engine, the top level and the testbench.
package pesa_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam logic [15:0] WEIGHT_THRESHOLD_RST = 16'd2;
	localparam logic [31:0] NO_HANDLE = 32'hFFFF_FFFF;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_UPDATE = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		STAT_ADDED_FREE  = 3'd0,
		STAT_ADDED_EVICT = 3'd1,
		STAT_INVALID     = 3'd2,
		STAT_FULL        = 3'd3,
		STAT_FOUND       = 3'd4,
		STAT_MISSING     = 3'd5,
		STAT_UPDATED     = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_EMIT
	} seq_state_t;

	// one slot table entry, as stored in the RAM
	typedef struct packed {
		logic [15:0] lifetime;
		logic [15:0] priority_val;
		logic [16:0] age;
		logic [31:0] frame;
		logic [31:0] handle;
	} slot_word_t;

	localparam int SLOT_WORD_W = $bits(slot_word_t);

	// request as handed to the engine
	typedef struct packed {
		logic [1:0]  kind;
		logic        bad;
		logic [15:0] lifetime;
		logic [15:0] priority_val;
		logic [31:0] query_handle;
		logic [31:0] frame_number;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] handle;
		logic [3:0]  slot;
		logic [4:0]  live_count;
	} res_t;

endpackage

[sv/pesa_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module pesa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/pesa_engine.sv]
`timescale 1ns / 1ps
// Slot table sequencer: one read-modify-write RAM scan per non-bad request.
// Depends on pesa_pkg and pesa_ram.
module pesa_engine
	import pesa_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic ready,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [IW:0] N_CNT = (IW + 1)'(NUM_SLOTS);

	seq_state_t state_q, state_d;

	req_t          req_q;
	logic [IW:0]   rd_idx_q;
	logic          rd_v_s1;
	logic [IW-1:0] idx_s1;

	logic [NUM_SLOTS-1:0] live_q;
	logic [NUM_SLOTS-1:0] written_q;

	logic          free_hit_q, vict_hit_q, find_hit_q;
	logic [IW-1:0] free_idx_q, vict_idx_q, find_idx_q;
	logic [15:0]   best_prio_q;
	logic [CW-1:0] live_cnt_q;
	logic [31:0]   next_handle_q;
	res_t          res_q;

	logic          ram_re, ram_we;
	logic [IW-1:0] ram_waddr;
	slot_word_t    ram_wdata, rword;
	logic [SLOT_WORD_W-1:0] ram_rdata;

	// slot being processed this cycle
	logic        cur_live, cur_written;
	logic [31:0] cur_handle;
	logic [16:0] new_age;
	logic [31:0] new_frame;
	logic        expired;
	logic        upd_wr;

	// commit decisions
	logic          do_add_wr;
	logic [IW-1:0] add_idx;

	pesa_ram #(
		.WIDTH(SLOT_WORD_W),
		.DEPTH(NUM_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_idx_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign rword       = slot_word_t'(ram_rdata);
	assign cur_live    = live_q[idx_s1];
	assign cur_written = written_q[idx_s1];
	assign cur_handle  = cur_written ? rword.handle : NO_HANDLE;

	always_comb begin
		new_age   = rword.age;
		new_frame = rword.frame;
		if (rword.frame != req_q.frame_number) begin
			new_age   = rword.age + 17'd1;
			new_frame = req_q.frame_number;
		end
	end

	assign expired = new_age > {1'b0, rword.lifetime};
	assign upd_wr  = rd_v_s1 && (req_q.kind == REQ_UPDATE) && cur_live;

	assign add_idx   = free_hit_q ? free_idx_q : vict_idx_q;
	assign do_add_wr = (state_q == ST_COMMIT) && !req_q.bad && (req_q.kind == REQ_ADD)
		&& (free_hit_q || vict_hit_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = req.bad ? ST_COMMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if ((rd_idx_q == N_CNT) && !rd_v_s1) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and RAM port control
	always_comb begin
		ready     = (state_q == ST_IDLE);
		res_valid = (state_q == ST_EMIT);
		ram_re    = (state_q == ST_SCAN) && (rd_idx_q < N_CNT);
		ram_we    = upd_wr || do_add_wr;
		ram_waddr = idx_s1;
		ram_wdata = rword;
		if (do_add_wr) begin
			ram_waddr              = add_idx;
			ram_wdata.lifetime     = req_q.lifetime;
			ram_wdata.priority_val = req_q.priority_val;
			ram_wdata.age          = 17'd0;
			ram_wdata.frame        = req_q.frame_number;
			ram_wdata.handle       = next_handle_q;
		end else begin
			ram_wdata.age   = new_age;
			ram_wdata.frame = new_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_idx_q      <= '0;
			rd_v_s1       <= 1'b0;
			live_q        <= '0;
			written_q     <= '0;
			next_handle_q <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= ram_re;
			if (start && ready) begin
				rd_idx_q <= '0;
			end else if (ram_re) begin
				rd_idx_q <= rd_idx_q + (IW + 1)'(1);
			end
			if (upd_wr && expired) begin
				live_q[idx_s1] <= 1'b0;
			end
			if (do_add_wr) begin
				live_q[add_idx]    <= 1'b1;
				written_q[add_idx] <= 1'b1;
				next_handle_q      <= next_handle_q + 32'd1;
			end
		end
	end

	// request capture, scan accumulators and result
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IW-1:0];
		if (start && ready) begin
			req_q       <= req;
			free_hit_q  <= 1'b0;
			vict_hit_q  <= 1'b0;
			find_hit_q  <= 1'b0;
			free_idx_q  <= '0;
			vict_idx_q  <= '0;
			find_idx_q  <= '0;
			best_prio_q <= req.priority_val;
			live_cnt_q  <= '0;
		end else if (rd_v_s1) begin
			case (req_q.kind)
				REQ_ADD: begin
					if (!cur_live && !free_hit_q) begin
						free_hit_q <= 1'b1;
						free_idx_q <= idx_s1;
					end
					if (cur_live && (rword.priority_val < best_prio_q)) begin
						best_prio_q <= rword.priority_val;
						vict_hit_q  <= 1'b1;
						vict_idx_q  <= idx_s1;
					end
				end
				REQ_LOOKUP: begin
					if (!find_hit_q && (cur_handle == req_q.query_handle)) begin
						find_hit_q <= 1'b1;
						find_idx_q <= idx_s1;
					end
				end
				REQ_UPDATE: begin
					if (cur_live && !expired) begin
						live_cnt_q <= live_cnt_q + CW'(1);
					end
				end
				default: ;
			endcase
		end

		if (state_q == ST_COMMIT) begin
			res_q.status     <= STAT_INVALID;
			res_q.handle     <= NO_HANDLE;
			res_q.slot       <= 4'd0;
			res_q.live_count <= 5'd0;
			if (!req_q.bad) begin
				case (req_q.kind)
					REQ_ADD: begin
						if (free_hit_q || vict_hit_q) begin
							res_q.status <= free_hit_q ? STAT_ADDED_FREE : STAT_ADDED_EVICT;
							res_q.handle <= next_handle_q;
							res_q.slot   <= 4'(add_idx);
						end else begin
							res_q.status <= STAT_FULL;
						end
					end
					REQ_LOOKUP: begin
						res_q.status <= find_hit_q ? STAT_FOUND : STAT_MISSING;
						res_q.slot   <= find_hit_q ? 4'(find_idx_q) : 4'd0;
					end
					REQ_UPDATE: begin
						res_q.status     <= STAT_UPDATED;
						res_q.live_count <= 5'(live_cnt_q);
					end
					default: ;
				endcase
			end
		end
	end

	assign res = res_q;

endmodule

[sv/priority_evicting_slot_allocator_unit.sv]
`timescale 1ns / 1ps
// Top level of the priority evicting slot allocator: request check, result register.
// Depends on pesa_pkg and pesa_engine (which holds the slot RAM).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | request item: tuser kind, tdata fields
//  m_*     | out | m_tvalid/m_tready  | result item: tuser status, tdata fields
//  cfg_*   | in  | cfg_we             | weight_threshold, 16 bit
//
// Flow: an add, lookup or update item goes from accept to m_tvalid through the scan,
// one slot RAM read per slot, then drain, commit and emit; a rejected add or an
// unused kind skips the scan. The next item is accepted the cycle after the result
// leaves the sequencer, so no item is taken before the last one's result is out of it.
// Reset: arst_n clears all live and handle-written bits, the handle counter and the
// threshold (to 2). The result register frees the sequencer while m_tready is low;
// a second result waits in the sequencer until the register empties.
module priority_evicting_slot_allocator_unit
	import pesa_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// lifetime, priority_req, radius, weight_sq, query_handle, frame_number
	input  logic [127:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// handle, slot, live_count, zero fill [47:41]
	output logic [47:0]  m_tdata,
	// status
	output logic [2:0]   m_tuser
);

	logic [15:0] weight_threshold_q;

	// unpacked request fields
	logic [1:0]         req_type;
	logic [15:0]        lifetime;
	logic [15:0]        priority_req;
	logic signed [15:0] radius;
	logic [15:0]        weight_sq;
	logic [31:0]        query_handle;
	logic [31:0]        frame_number;

	req_t req;
	res_t res;
	logic eng_ready, res_valid, res_take;

	logic        m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic [2:0]  m_tuser_q;

	assign req_type     = s_tuser;
	assign lifetime     = s_tdata[15:0];
	assign priority_req = s_tdata[31:16];
	assign radius       = $signed(s_tdata[47:32]);
	assign weight_sq    = s_tdata[63:48];
	assign query_handle = s_tdata[95:64];
	assign frame_number = s_tdata[127:96];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_threshold_q <= WEIGHT_THRESHOLD_RST;
		end else if (cfg_we) begin
			weight_threshold_q <= cfg_wdata;
		end
	end

	// reject check: unused kind, or an add with zero life, radius <= 0 or a weak weight
	always_comb begin
		req.kind         = req_type;
		req.lifetime     = lifetime;
		req.priority_val = priority_req;
		req.query_handle = query_handle;
		req.frame_number = frame_number;
		case (req_type)
			REQ_ADD:    req.bad = (lifetime == 16'd0) || (radius <= 16'sd0)
				|| (weight_sq <= weight_threshold_q);
			REQ_LOOKUP: req.bad = 1'b0;
			REQ_UPDATE: req.bad = 1'b0;
			REQ_UNUSED: req.bad = 1'b1;
			default:    req.bad = 1'b1;
		endcase
	end

	assign s_tready = eng_ready;

	pesa_engine #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid),
		.req      (req),
		.ready    (eng_ready),
		.res_valid(res_valid),
		.res_ready(res_take),
		.res      (res)
	);

	// result register, loaded whenever it is empty or being drained
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= {7'd0, res.live_count, res.slot, res.handle};
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for priority_evicting_slot_allocator_unit.
// Depends on pesa_pkg and the RTL; keeps its own slot table model and compares every result.

module tb;
	import pesa_pkg::*;

	localparam int SLOTS          = NUM_SLOTS_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 25;

	// one request item, fields unpacked
	typedef struct {
		logic [1:0]  kind;
		logic [15:0] lifetime;
		logic [15:0] priority_req;
		logic [15:0] radius;
		logic [15:0] weight_sq;
		logic [31:0] query_handle;
		logic [31:0] frame_number;
	} request_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;   // lifetime, priority_req, radius, weight_sq, query_handle, frame_number
	logic [1:0]   s_tuser = '0;   // req_type
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;        // handle, slot, live_count, zero fill
	logic [2:0]   m_tuser;        // status

	// slot table as the testbench sees it
	logic [15:0] tbl_lifetime [SLOTS] = '{default: '0};
	logic [15:0] tbl_prio     [SLOTS] = '{default: '0};
	logic [16:0] tbl_age      [SLOTS] = '{default: '0};
	logic [31:0] tbl_frame    [SLOTS] = '{default: '0};
	logic [31:0] tbl_handle   [SLOTS] = '{default: NO_HANDLE};
	logic [31:0] handle_ctr   = '0;
	logic [15:0] weight_limit = WEIGHT_THRESHOLD_RST;
	logic [31:0] cur_frame    = '0;

	res_t pending [$];

	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b0;
	bit rx_hold    = 1'b0;
	int rx_gap_left = 0;

	int mismatches   = 0;
	int requests_out = 0;
	int results_in   = 0;
	int status_seen [8] = '{default: 0};
	int stall_cycles = 0;

	priority_evicting_slot_allocator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Slot table predictor: applies one request, returns its result.
	// ------------------------------------------------------------------
	function automatic res_t compute_response(input request_t r);
		res_t        o;
		int          pick;
		logic [15:0] low_prio;
		logic [4:0]  live;
		o.status     = STAT_INVALID;
		o.handle     = NO_HANDLE;
		o.slot       = '0;
		o.live_count = '0;
		pick         = -1;
		case (r.kind)
			REQ_ADD: begin
				// screening: zero lifetime, radius not positive, weight too small
				if (r.lifetime == '0 || r.radius[15] || r.radius == '0 ||
					r.weight_sq <= weight_limit)
					return o;
				for (int i = 0; i < SLOTS; i++)
					if (pick < 0 && tbl_lifetime[i] == '0)
						pick = i;
				if (pick >= 0) begin
					o.status = STAT_ADDED_FREE;
				end else begin
					// strictly lower priority only; ties go to the lowest slot
					low_prio = r.priority_req;
					for (int i = 0; i < SLOTS; i++)
						if (tbl_prio[i] < low_prio) begin
							low_prio = tbl_prio[i];
							pick = i;
						end
					o.status = (pick >= 0) ? STAT_ADDED_EVICT : STAT_FULL;
				end
				if (pick >= 0) begin
					tbl_lifetime[pick] = r.lifetime;
					tbl_prio[pick]     = r.priority_req;
					tbl_age[pick]      = '0;
					tbl_frame[pick]    = r.frame_number;
					tbl_handle[pick]   = handle_ctr;
					o.handle           = handle_ctr;
					o.slot             = 4'(pick);
					handle_ctr         = handle_ctr + 32'd1;
				end
			end
			REQ_LOOKUP: begin
				// freed slots keep their handle, so they still match
				o.status = STAT_MISSING;
				for (int i = 0; i < SLOTS; i++)
					if (pick < 0 && tbl_handle[i] == r.query_handle)
						pick = i;
				if (pick >= 0) begin
					o.status = STAT_FOUND;
					o.slot   = 4'(pick);
				end
			end
			REQ_UPDATE: begin
				live = '0;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_lifetime[i] != '0) begin
						// age once per new frame number
						if (tbl_frame[i] != r.frame_number) begin
							tbl_age[i]   = tbl_age[i] + 17'd1;
							tbl_frame[i] = r.frame_number;
						end
						if (tbl_age[i] > {1'b0, tbl_lifetime[i]})
							tbl_lifetime[i] = '0;
						else
							live++;
					end
				end
				o.status     = STAT_UPDATED;
				o.live_count = live;
			end
			default: ;  // unused kind: invalid, no state change
		endcase
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Request builders
	// ------------------------------------------------------------------
	function automatic request_t add_request(input logic [15:0] life, input logic [15:0] prio,
			input logic [15:0] rad, input logic [15:0] wsq, input logic [31:0] frame);
		request_t r;
		r.kind         = REQ_ADD;
		r.lifetime     = life;
		r.priority_req = prio;
		r.radius       = rad;
		r.weight_sq    = wsq;
		r.query_handle = $urandom;
		r.frame_number = frame;
		return r;
	endfunction

	function automatic request_t lookup_request(input logic [31:0] h);
		request_t r;
		r = add_request(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
		r.kind         = REQ_LOOKUP;
		r.query_handle = h;
		return r;
	endfunction

	function automatic request_t update_request(input logic [31:0] frame);
		request_t r;
		r = lookup_request($urandom);
		r.kind         = REQ_UPDATE;
		r.frame_number = frame;
		return r;
	endfunction

	// Mostly well-formed traffic: valid adds at the current frame, lookups of
	// recent handles, frame updates that advance slowly; plus some noise.
	function automatic request_t make_random_request();
		request_t    r;
		int          pick;
		int          sel;
		logic [31:0] lo;
		r    = update_request($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			r.kind = REQ_UNUSED;
		end else if (pick < 62) begin
			r.kind         = REQ_ADD;
			r.lifetime     = 16'($urandom_range(1, 6));
			if ($urandom_range(0, 9) == 0)
				r.lifetime = 16'($urandom_range(1, 65535));
			r.priority_req = 16'($urandom_range(0, 24));
			if ($urandom_range(0, 9) == 0)
				r.priority_req = 16'($urandom);
			r.radius       = 16'($urandom_range(1, 32767));
			r.weight_sq    = (weight_limit == 16'hFFFF) ? 16'hFFFF :
				16'($urandom_range(int'(weight_limit) + 1, 65535));
			if ($urandom_range(0, 9) != 0)
				r.frame_number = cur_frame;
			// occasional broken add
			sel = $urandom_range(0, 19);
			case (sel)
				0: r.lifetime  = '0;
				1: r.radius    = 16'($urandom_range(32768, 65535));
				2: r.radius    = '0;
				3: r.weight_sq = 16'($urandom_range(0, int'(weight_limit)));
				default: ;
			endcase
		end else if (pick < 80) begin
			r.kind = REQ_LOOKUP;
			sel    = $urandom_range(0, 9);
			if (sel < 7 && handle_ctr != '0) begin
				lo = (handle_ctr > 48) ? handle_ctr - 48 : '0;
				r.query_handle = $urandom_range(lo, handle_ctr - 1);
			end else if (sel < 8) begin
				r.query_handle = NO_HANDLE;
			end
		end else begin
			r.kind = REQ_UPDATE;
			sel    = $urandom_range(0, 19);
			if (sel == 0)
				cur_frame = $urandom;
			else if (sel < 16)
				cur_frame = cur_frame + 1;
			r.frame_number = cur_frame;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	task automatic send_request(input request_t r);
		s_tvalid <= 1'b1;
		s_tuser  <= r.kind;
		s_tdata  <= {r.frame_number, r.query_handle, r.weight_sq, r.radius,
			r.priority_req, r.lifetime};
		do @(posedge clk); while (s_tready !== 1'b1);
		pending.push_back(compute_response(r));
		requests_out++;
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	// block is idle once every result is back; settle a little anyway
	task automatic set_weight_threshold(input logic [15:0] value);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		weight_limit = value;
	endtask

	// ------------------------------------------------------------------
	// Receiver side: random stall bursts, or a long hold
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else if (rx_gap_left > 0) begin
			m_tready    <= 1'b0;
			rx_gap_left <= rx_gap_left - 1;
		end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
			m_tready    <= 1'b0;
			rx_gap_left <= $urandom_range(0, 11);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result checker: oldest expectation first, field by field
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			results_in++;
			if (!$isunknown(m_tuser))
				status_seen[m_tuser]++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: status %0d tdata %h",
						$realtime, m_tuser, m_tdata);
			end else begin
				exp_r = pending.pop_front();
				if (m_tuser !== exp_r.status || m_tdata[31:0] !== exp_r.handle ||
					m_tdata[35:32] !== exp_r.slot || m_tdata[40:36] !== exp_r.live_count) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch, exp status %s handle %h slot %0d live %0d",
							$realtime, exp_r.status.name(), exp_r.handle, exp_r.slot,
							exp_r.live_count);
						$display("  got status %0d handle %h slot %0d live %0d",
							m_tuser, m_tdata[31:0], m_tdata[35:32], m_tdata[40:36]);
					end
				end
			end
		end
	end

	// no item moving on either side for too long ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else if (arst_n)
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no item moved for %0d cycles, %0d results outstanding",
				$realtime, stall_cycles, pending.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// fresh table: all-ones handle sits in slot 0, unused kind, empty update
	task automatic test_table_after_reset();
		send_request(lookup_request(NO_HANDLE));
		send_request(lookup_request(32'h0));
		send_request('{kind: REQ_UNUSED, lifetime: 16'hFFFF, priority_req: 16'hFFFF,
			radius: 16'h7FFF, weight_sq: 16'hFFFF, query_handle: NO_HANDLE,
			frame_number: 32'hFFFF_FFFF});
		send_request(update_request(32'd5));
	endtask

	// screening, fill, full, eviction with tie, aging and freeing
	task automatic test_add_screening_and_eviction();
		send_request(add_request(16'h0, 16'd1, 16'd1, 16'hFFFF, 32'd0));      // zero lifetime
		send_request(add_request(16'd1, 16'd1, 16'h0000, 16'hFFFF, 32'd0));   // zero radius
		send_request(add_request(16'd1, 16'd1, 16'h8000, 16'hFFFF, 32'd0));   // most negative
		send_request(add_request(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 32'd0));   // -1
		send_request(add_request(16'd1, 16'd1, 16'd1, weight_limit, 32'd0));  // at threshold
		// largest lifetime and priority, just above threshold
		send_request(add_request(16'hFFFF, 16'hFFFF, 16'h7FFF, weight_limit + 16'd1, 32'd0));
		for (int i = 1; i < SLOTS; i++)
			send_request(add_request(16'd1, 16'd100, 16'd1, 16'hFFFF, 32'd0));
		send_request(add_request(16'd3, 16'd100, 16'd1, 16'hFFFF, 32'd0));   // equal: full
		send_request(add_request(16'd1, 16'd101, 16'd1, 16'hFFFF, 32'd0));   // evicts slot 1
		send_request(lookup_request(32'd1));                                  // overwritten
		send_request(lookup_request(32'd16));
		send_request(update_request(32'd0));   // same frame, no aging
		send_request(update_request(32'd1));
		send_request(update_request(32'd2));   // short-lived slots expire
		send_request(lookup_request(32'd5));   // freed slot keeps its handle
		send_request(add_request(16'd2, 16'h0, 16'd1, 16'hFFFF, 32'd2));
		cur_frame = 32'd2;
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count)
			send_request(make_random_request());
	endtask

	// receiver holds off while the sender keeps offering; then a full drain
	task automatic test_output_backpressure();
		fork
			begin
				rx_hold <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		tx_idle_en = 1'b0;
		test_random_traffic(40);
		tx_idle_en = 1'b1;
		wait_for_results();
	endtask

	task automatic test_threshold_settings();
		set_weight_threshold(16'h0000);
		test_random_traffic(250);
		set_weight_threshold(16'hFFFF);   // every add is rejected
		test_random_traffic(100);
		set_weight_threshold(16'($urandom_range(16'h0100, 16'hF000)));
		test_random_traffic(500);
		set_weight_threshold(WEIGHT_THRESHOLD_RST);
	endtask

	task automatic test_streaming_no_idle();
		tx_idle_en = 1'b0;
		rx_idle_en <= 1'b0;
		test_random_traffic(350);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		rx_idle_en <= 1'b1;

		test_table_after_reset();
		test_add_screening_and_eviction();
		test_random_traffic(600);
		test_output_backpressure();
		test_threshold_settings();
		test_streaming_no_idle();

		wait_for_results();
		repeat (40) @(posedge clk);
		if (pending.size() != 0)
			mismatches++;

		$display("Covered %0d requests, %0d results: %0d free adds, %0d evictions, %0d full, %0d rejected,",
			requests_out, results_in, status_seen[STAT_ADDED_FREE], status_seen[STAT_ADDED_EVICT],
			status_seen[STAT_FULL], status_seen[STAT_INVALID]);
		$display("  %0d lookups hit, %0d missed, %0d frame updates; %0d mismatches",
			status_seen[STAT_FOUND], status_seen[STAT_MISSING], status_seen[STAT_UPDATED],
			mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
sv/pesa_pkg.sv
sv/pesa_ram.sv
sv/pesa_engine.sv
sv/priority_evicting_slot_allocator_unit.sv
tb/tb.sv
